FILE: src/ggbl_pkg.sv
// Shared types and constants for the geoid grid bilinear lookup core.
package ggbl_pkg;

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// query modes, settled when the position is decoded
	localparam logic [1:0] MODE_INTERP = 2'd0;
	localparam logic [1:0] MODE_EDGE   = 2'd1;
	localparam logic [1:0] MODE_ZERO   = 2'd2;

	// read steps: z11, z12, z21, z22
	localparam logic [1:0] STEP_FIRST       = 2'd0;
	localparam logic [1:0] STEP_LAST_INTERP = 2'd3;

	localparam int FRAC_BITS = 17;
	localparam logic [17:0] FRAC_ONE = 18'h20000;

	localparam logic signed [23:0] LAT_MAX   = 24'sd5898240;
	localparam logic signed [25:0] LON_MIN   = -26'sd11796480;
	localparam logic signed [25:0] LON_MAX   = 26'sd23592959;
	localparam logic signed [25:0] FULL_TURN = 26'sd23592960;

	// rounding half and bias removal, 127 m in 1/256 m
	localparam logic [41:0] ROUND_HALF  = 42'h000_0200_0000;
	localparam logic [16:0] BIAS_OFFSET = 17'd32512;

	// decoded item waiting at the memory port
	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [1:0]  mode;
		logic        wr_ok;
		logic [16:0] fx;
		logic [16:0] fy;
	} job_t;

	// tag travelling with each grid read
	typedef struct packed {
		logic        valid;
		logic [1:0]  step;
		logic        last;
		logic [1:0]  mode;
		logic [16:0] fx;
		logic [16:0] fy;
	} rd_tag_t;

endpackage

FILE: src/ggbl_front.sv
// Input register and position decode: saturation, row/column split, cell address base.
module ggbl_front import ggbl_pkg::*; #(
	parameter int GRID_COLS = 180,
	parameter int GRID_ROWS = 90,
	localparam int AW = $clog2(GRID_ROWS * GRID_COLS),
	localparam int CW = $clog2(GRID_COLS),
	localparam int RW = $clog2(GRID_ROWS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                kind,
	input  logic [13:0]         table_index,
	input  logic [7:0]          table_byte,
	input  logic signed [23:0]  latitude,
	input  logic signed [25:0]  longitude,
	input  logic                job_done,
	output job_t                job,
	output logic [AW-1:0]       row_base,
	output logic [CW-1:0]       col,
	output logic [CW-1:0]       colp1,
	output logic [13:0]         wr_addr,
	output logic [7:0]          wr_byte
);

	logic signed [23:0] lat_sat;
	logic signed [25:0] lon_sat;
	logic signed [25:0] lon_pos;
	logic [24:0]        y_full;
	logic               accept;
	logic               s1_move;

	logic               s1_valid;
	logic               kind_s1;
	logic [23:0]        y_s1;
	logic [24:0]        x_s1;
	logic [13:0]        idx_s1;
	logic [7:0]         byte_s1;

	logic [6:0]         ilat;
	logic [7:0]         ilon;
	logic               zero_d;
	logic               edge_d;
	logic [RW-1:0]      row_d;
	logic [CW-1:0]      col_d;
	logic [CW-1:0]      colp1_d;
	logic [1:0]         mode_d;
	logic               wr_ok_d;

	logic               s2_valid;
	job_t               job_s2;
	logic [AW-1:0]      row_base_s2;
	logic [CW-1:0]      col_s2;
	logic [CW-1:0]      colp1_s2;
	logic [13:0]        idx_s2;
	logic [7:0]         byte_s2;

	// clamp to the legal ranges, fold western longitudes
	always_comb begin
		if (latitude > LAT_MAX) begin
			lat_sat = LAT_MAX;
		end else if (latitude < -LAT_MAX) begin
			lat_sat = -LAT_MAX;
		end else begin
			lat_sat = latitude;
		end
		if (longitude > LON_MAX) begin
			lon_sat = LON_MAX;
		end else if (longitude < LON_MIN) begin
			lon_sat = LON_MIN;
		end else begin
			lon_sat = longitude;
		end
		lon_pos = lon_sat[25] ? (lon_sat + FULL_TURN) : lon_sat;
		y_full  = 25'(LAT_MAX) - 25'(lat_sat);
	end

	assign s1_move    = s1_valid && (!s2_valid || job_done);
	assign item_stall = s1_valid && !s1_move;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_move) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			y_s1    <= y_full[23:0];
			x_s1    <= lon_pos[24:0];
			idx_s1  <= table_index;
			byte_s1 <= table_byte;
		end
	end

	// row and column, 17 fractional bits each
	always_comb begin
		ilat    = y_s1[23:FRAC_BITS];
		ilon    = x_s1[24:FRAC_BITS];
		zero_d  = (32'(ilat) > GRID_ROWS) || (32'(ilon) >= GRID_COLS);
		edge_d  = !zero_d && (32'(ilat) >= GRID_ROWS - 1);
		row_d   = (zero_d || edge_d) ? RW'(GRID_ROWS - 1) : RW'(ilat);
		col_d   = zero_d ? '0 : CW'(ilon);
		colp1_d = (!zero_d && (32'(ilon) == GRID_COLS - 1)) ? '0 : (col_d + CW'(1));
		if (zero_d) begin
			mode_d = MODE_ZERO;
		end else if (edge_d) begin
			mode_d = MODE_EDGE;
		end else begin
			mode_d = MODE_INTERP;
		end
		wr_ok_d = 32'(idx_s1) < GRID_ROWS * GRID_COLS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_move) begin
			s2_valid <= 1'b1;
		end else if (job_done) begin
			s2_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			job_s2.kind  <= kind_s1;
			job_s2.mode  <= mode_d;
			job_s2.wr_ok <= wr_ok_d;
			job_s2.fx    <= x_s1[FRAC_BITS-1:0];
			job_s2.fy    <= y_s1[FRAC_BITS-1:0];
			row_base_s2  <= AW'(row_d) * AW'(GRID_COLS);
			col_s2       <= col_d;
			colp1_s2     <= colp1_d;
			idx_s2       <= idx_s1;
			byte_s2      <= byte_s1;
		end
	end

	always_comb begin
		job.valid = s2_valid;
		job.kind  = job_s2.kind;
		job.mode  = job_s2.mode;
		job.wr_ok = job_s2.wr_ok;
		job.fx    = job_s2.fx;
		job.fy    = job_s2.fy;
	end

	assign row_base = row_base_s2;
	assign col      = col_s2;
	assign colp1    = colp1_s2;
	assign wr_addr  = idx_s2;
	assign wr_byte  = byte_s2;

endmodule

FILE: src/ggbl_grid_mem.sv
// Height grid memory with its read sequencer: one write or up to four reads per item.
module ggbl_grid_mem import ggbl_pkg::*; #(
	parameter int GRID_COLS = 180,
	parameter int GRID_ROWS = 90,
	localparam int SIZE = GRID_ROWS * GRID_COLS,
	localparam int AW = $clog2(SIZE),
	localparam int CW = $clog2(GRID_COLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  job_t          job,
	input  logic [AW-1:0] row_base,
	input  logic [CW-1:0] col,
	input  logic [CW-1:0] colp1,
	input  logic [13:0]   wr_addr,
	input  logic [7:0]    wr_byte,
	output logic          job_done,
	output rd_tag_t       rd,
	output logic [7:0]    rdata
);

	logic [7:0]    grid_mem [0:SIZE-1];

	logic [1:0]    step_q;
	logic [1:0]    last_step;
	logic          issue_rd;
	logic          issue_wr;
	logic [AW-1:0] raddr;
	logic [AW-1:0] addr;

	logic          rd_valid_s3;
	logic [1:0]    rd_step_s3;
	logic          rd_last_s3;
	logic [1:0]    rd_mode_s3;
	logic [16:0]   rd_fx_s3;
	logic [16:0]   rd_fy_s3;
	logic [7:0]    rdata_s3;

	assign last_step = (job.kind == KIND_QUERY && job.mode == MODE_INTERP) ?
		STEP_LAST_INTERP : STEP_FIRST;
	assign job_done  = job.valid && en && (step_q == last_step);
	assign issue_rd  = job.valid && en && (job.kind == KIND_QUERY);
	assign issue_wr  = job.valid && en && (job.kind == KIND_WRITE) && job.wr_ok;

	// step bit 1 picks the southern row, bit 0 the eastern column
	assign raddr = row_base + (step_q[1] ? AW'(GRID_COLS) : '0)
		+ (step_q[0] ? AW'(colp1) : AW'(col));
	assign addr  = issue_wr ? AW'(wr_addr) : raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FIRST;
		end else if (job_done) begin
			step_q <= STEP_FIRST;
		end else if (job.valid && en) begin
			step_q <= step_q + 2'd1;
		end
	end

	// single port
	always_ff @(posedge clk) begin
		if (issue_wr) begin
			grid_mem[addr] <= wr_byte;
		end else if (issue_rd) begin
			rdata_s3 <= grid_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s3 <= 1'b0;
		end else if (en) begin
			rd_valid_s3 <= issue_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_step_s3 <= step_q;
			rd_last_s3 <= step_q == last_step;
			rd_mode_s3 <= job.mode;
			rd_fx_s3   <= job.fx;
			rd_fy_s3   <= job.fy;
		end
	end

	always_comb begin
		rd.valid = rd_valid_s3;
		rd.step  = rd_step_s3;
		rd.last  = rd_last_s3;
		rd.mode  = rd_mode_s3;
		rd.fx    = rd_fx_s3;
		rd.fy    = rd_fy_s3;
	end

	assign rdata = rdata_s3;

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!job.valid |-> step_q == STEP_FIRST)
		else $error("sequencer step left over without a job");

	a_step_single: assert property (@(posedge clk) disable iff (!arst_n)
		(job.valid && job.kind == KIND_QUERY && job.mode != MODE_INTERP) |->
		step_q == STEP_FIRST)
		else $error("single read query went past its first step");

	a_last_interp: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s3 && rd_last_s3 && rd_mode_s3 == MODE_INTERP) |->
		rd_step_s3 == STEP_LAST_INTERP)
		else $error("interpolating query closed before its fourth read");

	a_raddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue_rd |-> 32'(raddr) < SIZE)
		else $error("grid read address beyond the grid");

endmodule

FILE: src/ggbl_interp.sv
// Corner collection and bilinear blend: x pass, y pass, then result select.
module ggbl_interp import ggbl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  rd_tag_t            rd,
	input  logic [7:0]         rdata,
	output logic               res_valid,
	output logic signed [16:0] res_value
);

	logic [7:0]  u_s4 [0:3];
	logic        s4_valid;
	logic [1:0]  mode_s4;
	logic [16:0] fx_s4;
	logic [16:0] fy_s4;

	logic        s5_valid;
	logic [1:0]  mode_s5;
	logic [16:0] fy_s5;
	logic [7:0]  u0_s5;
	logic [24:0] a_s5;
	logic [24:0] b_s5;

	logic        s6_valid;
	logic [1:0]  mode_s6;
	logic [7:0]  u0_s6;
	logic [41:0] p_s6;
	logic [41:0] q_s6;

	logic [17:0] wx0;
	logic [17:0] wy0;
	logic [41:0] sum;

	assign wx0 = FRAC_ONE - 18'(fx_s4);
	assign wy0 = FRAC_ONE - 18'(fy_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_valid <= 1'b0;
			s5_valid <= 1'b0;
			s6_valid <= 1'b0;
		end else if (en) begin
			s4_valid <= rd.valid && rd.last;
			s5_valid <= s4_valid;
			s6_valid <= s5_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rd.valid) begin
				u_s4[rd.step] <= rdata;
			end
			mode_s4 <= rd.mode;
			fx_s4   <= rd.fx;
			fy_s4   <= rd.fy;

			// along the row, biased bytes kept unsigned
			a_s5    <= 25'(u_s4[0]) * 25'(wx0) + 25'(u_s4[1]) * 25'(fx_s4);
			b_s5    <= 25'(u_s4[2]) * 25'(wx0) + 25'(u_s4[3]) * 25'(fx_s4);
			mode_s5 <= mode_s4;
			fy_s5   <= fy_s4;
			u0_s5   <= u_s4[0];

			// across the rows
			p_s6    <= 42'(a_s5) * 42'(wy0);
			q_s6    <= 42'(b_s5) * 42'(fy_s5);
			mode_s6 <= mode_s5;
			u0_s6   <= u0_s5;
		end
	end

	assign sum = p_s6 + q_s6 + ROUND_HALF;

	always_comb begin
		case (mode_s6)
			MODE_INTERP: res_value = $signed(17'({1'b0, sum[41:26]}) - BIAS_OFFSET);
			MODE_EDGE:   res_value = $signed(17'({1'b0, u0_s6, 8'h00}) - BIAS_OFFSET);
			default:     res_value = '0;
		endcase
	end

	assign res_valid = s6_valid;

endmodule

FILE: src/geoid_grid_bilinear_lookup_core.sv
// Top level of the geoid grid bilinear lookup core.
//
// One input channel (item_valid / item_stall) carries both kinds of beat:
// a write beat loads one biased height byte at table_index, a query beat
// carries latitude and longitude in 2^-16 degree units. Each query gives
// exactly one beat on the result channel (result_valid / result_stall):
// the geoid separation in 1/256 m. Writes give no result.
// Each item holds the single grid memory port for its accesses: four reads
// for a query interpolating between four corners, one read for a query on
// the southern edge rows or outside the grid, one write for a write.
// A query passes the input, decode, memory read, corner, row blend, column
// blend and output registers; a result stall can hold it on the way.
// A write followed by a query sees the new byte; accesses keep item order.
// The grid contents are undefined after reset until written; reset clears
// only the pipeline and handshake state, so the block is ready at once.
// While result_stall holds a waiting result the memory sequencer and the
// blend pipeline freeze; the input and decode registers still fill before
// item_stall rises.
module geoid_grid_bilinear_lookup_core import ggbl_pkg::*; #(
	parameter int GRID_COLS = 180,
	parameter int GRID_ROWS = 90
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               kind,
	input  logic [13:0]        table_index,
	input  logic [7:0]         table_byte,
	input  logic signed [23:0] latitude,
	input  logic signed [25:0] longitude,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [16:0] separation
);

	localparam int AW = $clog2(GRID_ROWS * GRID_COLS);
	localparam int CW = $clog2(GRID_COLS);

	logic               en;
	logic               job_done;
	job_t               job;
	logic [AW-1:0]      row_base;
	logic [CW-1:0]      col;
	logic [CW-1:0]      colp1;
	logic [13:0]        wr_addr;
	logic [7:0]         wr_byte;
	rd_tag_t            rd;
	logic [7:0]         rdata;
	logic               res_valid;
	logic signed [16:0] res_value;

	logic               out_valid_q;
	logic signed [16:0] separation_q;

	// everything behind the decode stage moves only when the output can
	assign en = !(out_valid_q && result_stall);

	ggbl_front #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.table_index (table_index),
		.table_byte  (table_byte),
		.latitude    (latitude),
		.longitude   (longitude),
		.job_done    (job_done),
		.job         (job),
		.row_base    (row_base),
		.col         (col),
		.colp1       (colp1),
		.wr_addr     (wr_addr),
		.wr_byte     (wr_byte)
	);

	ggbl_grid_mem #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_grid_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.job      (job),
		.row_base (row_base),
		.col      (col),
		.colp1    (colp1),
		.wr_addr  (wr_addr),
		.wr_byte  (wr_byte),
		.job_done (job_done),
		.rd       (rd),
		.rdata    (rdata)
	);

	ggbl_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.rd        (rd),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	// output register: a result beat holds here while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			separation_q <= res_value;
		end
	end

	assign result_valid = out_valid_q;
	assign separation   = separation_q;

endmodule

FILE: test/geoid_grid_bilinear_lookup_core_tb.sv
// Self-checking testbench for the geoid grid bilinear lookup core.
module geoid_grid_bilinear_lookup_core_tb import ggbl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_COLS = 180;
	localparam int GRID_ROWS = 90;
	localparam int GRID_SIZE = GRID_ROWS * GRID_COLS;
	localparam longint HEIGHT_BIAS = 127;
	localparam int ROW_STEP = 1 << FRAC_BITS;      // one grid row/column in 2^-16 deg
	localparam int Y_SPAN = 2 * 5898240;            // pole to pole in 2^-16 deg
	localparam int ITEMS = 1950;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 600000;

	// Keeps its own copy of the height grid and the separations still owed
	// by the block, oldest first.
	class sep_board;
		logic [7:0] heights [GRID_SIZE];
		logic signed [16:0] owed [$];
		int errors;

		function new();
			foreach (heights[i]) heights[i] = '0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// Saturate the position, fold negative longitude, split into cell and fractions.
		static function void locate(input logic signed [23:0] lat,
				input logic signed [25:0] lon, output int row, output int col,
				output longint fy, output longint fx);
			longint la, lo, y;
			la = lat;
			lo = lon;
			if (la > LAT_MAX) la = LAT_MAX;
			if (la < -LAT_MAX) la = -LAT_MAX;
			if (lo > LON_MAX) lo = LON_MAX;
			if (lo < LON_MIN) lo = LON_MIN;
			if (lo < 0) lo += FULL_TURN;
			y = LAT_MAX - la;
			row = int'(y >>> FRAC_BITS);
			col = int'(lo >>> FRAC_BITS);
			fy = y & (ROW_STEP - 1);
			fx = lo & (ROW_STEP - 1);
		endfunction

		function longint height_at(int row, int col);
			return longint'(heights[row * GRID_COLS + col]) - HEIGHT_BIAS;
		endfunction

		function logic signed [16:0] geoid_separation(logic signed [23:0] lat,
				logic signed [25:0] lon);
			int row, col, col_e;
			longint fy, fx, gy, gx, acc, t;
			locate(lat, lon, row, col, fy, fx);
			if (row > GRID_ROWS || col >= GRID_COLS) return '0;
			// southern edge rows: raw byte, no blend
			if (row >= GRID_ROWS - 1) return 17'(height_at(GRID_ROWS - 1, col) * 256);
			col_e = (col == GRID_COLS - 1) ? 0 : col + 1;
			gx = ROW_STEP - fx;
			gy = ROW_STEP - fy;
			acc = height_at(row + 1, col_e) * (fx * fy)
				+ height_at(row, col_e) * (fx * gy)
				+ height_at(row + 1, col) * (gx * fy)
				+ height_at(row, col) * (gx * gy);
			// shift positive, round half up, shift back
			t = acc + (HEIGHT_BIAS <<< 34) + (longint'(1) <<< 25);
			return 17'((t >>> 26) - HEIGHT_BIAS * 256);
		endfunction

		function void note_beat(logic k, logic [13:0] idx, logic [7:0] byt,
				logic signed [23:0] lat, logic signed [25:0] lon);
			if (k == KIND_WRITE) begin
				if (idx < GRID_SIZE) heights[idx] = byt;
			end else begin
				owed.push_back(geoid_separation(lat, lon));
			end
		endfunction

		task check(logic signed [16:0] got);
			logic signed [16:0] want;
			if (owed.size() == 0) begin
				report($sformatf("result beat %0d with no query outstanding", got));
			end else begin
				want = owed.pop_front();
				if (got !== want)
					report($sformatf("separation %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic               kind;
	logic [13:0]        table_index;
	logic [7:0]         table_byte;
	logic signed [23:0] latitude;
	logic signed [25:0] longitude;
	logic               result_valid;
	logic               result_stall;
	logic signed [16:0] separation;

	sep_board board = new();
	bit written [GRID_SIZE];    // grid cells the stimulus has already loaded
	int send_idle_pct;
	int stall_pct;
	bit hold_req;
	int beats_sent;
	int cycle_count;

	geoid_grid_bilinear_lookup_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.kind(kind), .table_index(table_index), .table_byte(table_byte),
		.latitude(latitude), .longitude(longitude),
		.result_valid(result_valid), .result_stall(result_stall),
		.separation(separation)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one beat, after a random gap, and wait for it to be taken.
	// Valid stays high across back-to-back beats.
	task automatic send_beat(logic k, logic [13:0] idx, logic [7:0] byt,
			logic signed [23:0] lat, logic signed [25:0] lon);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		item_valid  <= 1'b1;
		kind        <= k;
		table_index <= idx;
		table_byte  <= byt;
		latitude    <= lat;
		longitude   <= lon;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		beats_sent++;
	endtask

	task automatic write_byte(int a, logic [7:0] byt);
		if (a < GRID_SIZE) written[a] = 1'b1;
		send_beat(KIND_WRITE, 14'(a), byt, 24'($urandom), 26'($urandom));
	endtask

	// Cells are loaded before the first query that reads them.
	task automatic fill_cell(int row, int col);
		int a;
		a = row * GRID_COLS + col;
		if (!written[a]) write_byte(a, 8'($urandom_range(255)));
	endtask

	task automatic send_query(logic signed [23:0] lat, logic signed [25:0] lon);
		int row, col;
		longint fy, fx;
		sep_board::locate(lat, lon, row, col, fy, fx);
		if (row >= GRID_ROWS - 1) begin
			fill_cell(GRID_ROWS - 1, col);
		end else begin
			fill_cell(row, col);
			fill_cell(row, (col + 1) % GRID_COLS);
			fill_cell(row + 1, col);
			fill_cell(row + 1, (col + 1) % GRID_COLS);
		end
		send_beat(KIND_QUERY, 14'($urandom), 8'($urandom), lat, lon);
	endtask

	// Small patch near the pole, the southern edge and the meridian, so that
	// cells get reused and rewritten.
	function automatic void pick_hot(output int r, output int c);
		r = $urandom_range(1) ? $urandom_range(5) : $urandom_range(GRID_ROWS, 84);
		c = $urandom_range(1) ? $urandom_range(3) : $urandom_range(GRID_COLS - 1, 176);
	endfunction

	function automatic longint pick_frac();
		case ($urandom_range(3))
			0: return 0;
			1: return ROW_STEP - 1;
			default: return $urandom_range(ROW_STEP - 1);
		endcase
	endfunction

	task automatic random_write();
		int r, c;
		pick_hot(r, c);
		if ($urandom_range(1)) write_byte(r * GRID_COLS + c, 8'($urandom_range(255)));
		else write_byte($urandom_range(16383), 8'($urandom_range(255)));
	endtask

	// negative y: send the raw port values as they are
	task automatic send_query_pos(longint y, longint x, logic signed [23:0] lat_raw,
			logic signed [25:0] lon_raw);
		logic signed [23:0] lat;
		logic signed [25:0] lon;
		if (y < 0) begin
			lat = lat_raw;
			lon = lon_raw;
		end else begin
			lat = 24'(LAT_MAX - y);
			// east half may also be given as a negative longitude
			if (x >= FULL_TURN / 2 && $urandom_range(1)) lon = 26'(x - FULL_TURN);
			else lon = 26'(x);
		end
		send_query(lat, lon);
	endtask

	task automatic random_query();
		int r, c;
		longint y, x;
		logic signed [23:0] lat;
		logic signed [25:0] lon;
		lat = '0;
		lon = '0;
		case ($urandom_range(9))
			0: begin
				// anything the ports can carry, out of range included
				lat = 24'($urandom);
				lon = 26'($urandom);
				y = -1;
				x = 0;
			end
			1, 2, 3: begin
				y = $urandom_range(Y_SPAN);
				x = $urandom_range(int'(LON_MAX));
			end
			default: begin
				pick_hot(r, c);
				y = longint'(r) * ROW_STEP + pick_frac();
				if (y > Y_SPAN) y = Y_SPAN;
				x = longint'(c) * ROW_STEP + pick_frac();
			end
		endcase
		send_query_pos(y, x, lat, lon);
	endtask

	initial begin
		int ph, start, quarter;
		int idle_tbl [4];
		int stall_tbl [4];
		idle_tbl  = '{0, 82, 0, 33};
		stall_tbl = '{0, 0, 82, 33};
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		kind        = KIND_WRITE;
		table_index = '0;
		table_byte  = '0;
		latitude    = '0;
		longitude   = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b0;
		beats_sent    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme bytes, pole corners, meridian, saturation, edge rows
		write_byte(0, 8'h00);
		write_byte(1, 8'hFF);
		write_byte(GRID_COLS, 8'hFF);
		write_byte(GRID_COLS + 1, 8'h00);
		send_query(LAT_MAX, 26'sd0);                            // exact corner, lowest height
		send_query(24'(LAT_MAX - 65536), 26'sd65536);           // centre of the first cell
		write_byte(16383, 8'hA5);                               // past the grid, dropped
		write_byte(GRID_COLS - 1, 8'hFF);
		write_byte(2 * GRID_COLS - 1, 8'h80);
		send_query(24'(LAT_MAX - 1), -26'sd1);                  // last column wraps to column 0
		write_byte((GRID_ROWS - 1) * GRID_COLS, 8'hFF);
		send_query(-LAT_MAX, 26'sd0);                           // south pole, highest height
		send_query(24'(-LAT_MAX + 65536), 26'sd32768);          // inside the last row
		send_query(24'sh7FFFFF, 26'sh2000000);                  // both saturate
		send_query(24'sh800000, 26'sh1FFFFFF);
		send_query(24'(LAT_MAX - 88 * ROW_STEP - 100), LON_MIN); // last blended row, -180 deg

		// random, in phases of sender gaps and receiver stalls
		start = beats_sent;
		quarter = (ITEMS - start) / 4;
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tbl[ph];
			stall_pct     = stall_tbl[ph];
			// long receiver hold-off while the sender keeps offering
			if (ph == 0) hold_req = 1'b1;
			while (beats_sent < start + quarter * (ph + 1)) begin
				if ($urandom_range(99) < 20) random_write();
				else random_query();
			end
		end
		item_valid <= 1'b0;

		while (board.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		int n;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				for (n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			board.note_beat(kind, table_index, table_byte, latitude, longitude);
		if (arst_n && result_valid && !result_stall)
			board.check(separation);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		board.report("run timed out");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
